/* rtl/core/midi_file_track_event_parser_assert.svh */
// ---------------------------------------------------------------------------
// midi_file_track_event_parser assertion macros
// Shared property macros for the MIDI file track parser.
// ---------------------------------------------------------------------------
`ifndef MIDI_FILE_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_FILE_TRACK_EVENT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MFTP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define MFTP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mftp_pkg.sv */
// ---------------------------------------------------------------------------
// mftp_pkg
// Types and constants shared by the MIDI file track parser modules.
// ---------------------------------------------------------------------------
package mftp_pkg;

  // Width of the internal tick counter; the tick port shows its low 32 bits.
  localparam int TICK_BITS = 32;

  // File magic words
  localparam logic [31:0] MAGIC_MTHD = 32'h4d546864;
  localparam logic [31:0] MAGIC_MTRK = 32'h4d54726b;

  // Status byte codes
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_PROG_CHG  = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRES = 8'hD0;
  localparam logic [7:0] ST_PITCH_BND = 8'hE0;
  localparam logic [7:0] TYPE_MASK    = 8'hF0;
  localparam logic [7:0] LOW7_MASK    = 8'h7F;

  // Result kinds
  localparam logic [2:0] K_NOTE_OFF  = 3'd0;
  localparam logic [2:0] K_NOTE_ON   = 3'd1;
  localparam logic [2:0] K_BAD_MAGIC = 3'd2;
  localparam logic [2:0] K_SMPTE     = 3'd3;
  localparam logic [2:0] K_UNKNOWN   = 3'd4;

  // Byte counts of fixed header fields
  localparam logic [2:0] LEN_WORD = 3'd4;
  localparam logic [2:0] LEN_DIV  = 3'd2;

  // Parser phases
  typedef enum logic [3:0] {
    PH_MAGIC    = 4'd0,
    PH_HDRLEN   = 4'd1,
    PH_FMT      = 4'd2,
    PH_DIV      = 4'd3,
    PH_TRKMAGIC = 4'd4,
    PH_TRKLEN   = 4'd5,
    PH_DELTA    = 4'd6,
    PH_STATUS   = 4'd7,
    PH_DATA1    = 4'd8,
    PH_DATA2    = 4'd9,
    PH_METATYPE = 4'd10,
    PH_SKIPLEN  = 4'd11,
    PH_SKIP     = 4'd12,
    PH_DONE     = 4'd13
  } phase_t;

  // One input byte with its file start mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } mftp_item_t;

  // One result
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  pitch;
    logic [7:0]  velocity;
    logic [31:0] tick;
  } mftp_result_t;

endpackage

/* rtl/core/mftp_in_reg.sv */
// ---------------------------------------------------------------------------
// mftp_in_reg
// Input register: holds one byte until the parser consumes it.
// ---------------------------------------------------------------------------
module mftp_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mftp_pkg::mftp_item_t in_item,
  input  logic               take,
  output logic               item_valid,
  output mftp_pkg::mftp_item_t item
);
  import mftp_pkg::*;

  // Stall only while a held byte cannot move on
  assign in_stall = item_valid && !take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

endmodule

/* rtl/core/mftp_step.sv */
// ---------------------------------------------------------------------------
// mftp_step
// Parser state and the per-byte decode: header checks, track length,
// delta times, running status, skip lengths and note events.
// ---------------------------------------------------------------------------
`include "midi_file_track_event_parser_assert.svh"

module mftp_step (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  mftp_pkg::mftp_item_t   item,
  output logic                   res_valid,
  output mftp_pkg::mftp_result_t res
);
  import mftp_pkg::*;

  // State registers
  phase_t                 phase;
  logic [2:0]             hdr_count;
  logic [31:0]            track_remaining;
  logic [31:0]            length_acc;
  logic [TICK_BITS-1:0]   tick_count;
  logic [7:0]             run_status;
  logic [7:0]             current_status;
  logic [7:0]             held_pitch;
  logic [31:0]            skip_remaining;
  logic                   halted;

  phase_t                 phase_next;
  logic [2:0]             hdr_count_next;
  logic [31:0]            track_remaining_next;
  logic [31:0]            length_acc_next;
  logic [TICK_BITS-1:0]   tick_count_next;
  logic [7:0]             run_status_next;
  logic [7:0]             current_status_next;
  logic [7:0]             held_pitch_next;
  logic [31:0]            skip_remaining_next;
  logic                   halted_next;

  // State as seen by this byte (file start restarts everything)
  phase_t                 cur_phase;
  logic [2:0]             cur_count;
  logic [31:0]            cur_track;
  logic [31:0]            cur_acc;
  logic [TICK_BITS-1:0]   cur_tick;
  logic [7:0]             cur_rs;
  logic [7:0]             cur_cs;
  logic [7:0]             cur_pitch;
  logic [31:0]            cur_skip;
  logic                   cur_halted;

  logic [7:0]  b;
  logic        active;
  logic [2:0]  count_inc;
  logic        collect_done;
  logic [31:0] acc_shift8;
  logic [31:0] acc_shift7;
  logic [31:0] track_dec;
  logic [31:0] skip_dec;
  phase_t      end_phase;
  logic [7:0]  st_cs;
  logic [7:0]  st_type;
  logic [7:0]  d1_type;
  logic [7:0]  cs_type;
  logic        st_meta;
  logic        st_sysex;
  logic        st_bad;
  logic        res_err;

  assign b = item.data_byte;

  // Restart on file start
  always_comb begin
    if (item.file_start) begin
      cur_phase  = PH_MAGIC;
      cur_count  = '0;
      cur_track  = '0;
      cur_acc    = '0;
      cur_tick   = '0;
      cur_rs     = '0;
      cur_cs     = '0;
      cur_pitch  = '0;
      cur_skip   = '0;
      cur_halted = 1'b0;
    end else begin
      cur_phase  = phase;
      cur_count  = hdr_count;
      cur_track  = track_remaining;
      cur_acc    = length_acc;
      cur_tick   = tick_count;
      cur_rs     = run_status;
      cur_cs     = current_status;
      cur_pitch  = held_pitch;
      cur_skip   = skip_remaining;
      cur_halted = halted;
    end
  end

  // Shared decode terms
  assign active       = !cur_halted && (cur_phase != PH_DONE);
  assign count_inc    = cur_count + 3'd1;
  assign collect_done = count_inc >= ((cur_phase == PH_DIV) ? LEN_DIV : LEN_WORD);
  assign acc_shift8   = {cur_acc[23:0], b};
  assign acc_shift7   = {cur_acc[24:0], b[6:0]};
  assign track_dec    = ((cur_phase >= PH_DELTA) && (cur_track != '0)) ?
                        cur_track - 32'd1 : cur_track;
  assign skip_dec     = (cur_skip != '0) ? cur_skip - 32'd1 : cur_skip;
  assign end_phase    = (track_dec == '0) ? PH_DONE : PH_DELTA;

  // Status byte decode, running status applied
  assign st_cs    = b[7] ? b : cur_rs;
  assign st_type  = st_cs & TYPE_MASK;
  assign st_meta  = (st_cs == ST_META);
  assign st_sysex = (st_cs == ST_SYSEX) || (st_cs == ST_SYSEX_ESC);
  assign st_bad   = (st_type < ST_NOTE_OFF) || (st_type > ST_PITCH_BND);
  assign cs_type  = cur_cs & TYPE_MASK;
  assign d1_type  = (cur_phase == PH_STATUS) ? st_type : cs_type;

  // Next state
  always_comb begin
    phase_next           = cur_phase;
    hdr_count_next       = cur_count;
    track_remaining_next = cur_track;
    length_acc_next      = cur_acc;
    tick_count_next      = cur_tick;
    run_status_next      = cur_rs;
    current_status_next  = cur_cs;
    held_pitch_next      = cur_pitch;
    skip_remaining_next  = cur_skip;
    halted_next          = cur_halted;
    if (active) begin
      track_remaining_next = track_dec;
      case (cur_phase)
        PH_MAGIC, PH_HDRLEN, PH_FMT, PH_DIV, PH_TRKMAGIC, PH_TRKLEN: begin
          length_acc_next = acc_shift8;
          hdr_count_next  = count_inc;
          if (collect_done) begin
            length_acc_next = '0;
            hdr_count_next  = '0;
            case (cur_phase)
              PH_MAGIC: begin
                if (acc_shift8 != MAGIC_MTHD) halted_next = 1'b1;
                else phase_next = PH_HDRLEN;
              end
              PH_HDRLEN: phase_next = PH_FMT;
              PH_FMT:    phase_next = PH_DIV;
              PH_DIV: begin
                if (acc_shift8[15]) halted_next = 1'b1;
                else phase_next = PH_TRKMAGIC;
              end
              PH_TRKMAGIC: begin
                if (acc_shift8 != MAGIC_MTRK) halted_next = 1'b1;
                else phase_next = PH_TRKLEN;
              end
              default: begin
                // track length loaded, track starts
                track_remaining_next = acc_shift8;
                tick_count_next      = '0;
                run_status_next      = '0;
                phase_next           = (acc_shift8 == '0) ? PH_DONE : PH_DELTA;
              end
            endcase
          end
        end
        PH_DELTA: begin
          length_acc_next = acc_shift7;
          if (!b[7]) begin
            tick_count_next = cur_tick + TICK_BITS'(acc_shift7);
            length_acc_next = '0;
            phase_next      = PH_STATUS;
          end
        end
        PH_STATUS, PH_DATA1: begin
          if (cur_phase == PH_STATUS) begin
            current_status_next = st_cs;
            if (b[7] && (b < ST_SYSEX)) run_status_next = b;
          end
          if ((cur_phase == PH_STATUS) && st_meta) begin
            run_status_next = '0;
            phase_next      = PH_METATYPE;
          end else if ((cur_phase == PH_STATUS) && st_sysex) begin
            run_status_next = '0;
            length_acc_next = '0;
            phase_next      = PH_SKIPLEN;
          end else if ((cur_phase == PH_STATUS) && st_bad) begin
            halted_next = 1'b1;
          end else if ((cur_phase == PH_STATUS) && b[7]) begin
            phase_next = PH_DATA1;
          end else if ((d1_type == ST_PROG_CHG) || (d1_type == ST_CHAN_PRES)) begin
            phase_next = end_phase;
          end else begin
            held_pitch_next = b;
            phase_next      = PH_DATA2;
          end
        end
        PH_DATA2: phase_next = end_phase;
        PH_METATYPE: begin
          length_acc_next = '0;
          phase_next      = PH_SKIPLEN;
        end
        PH_SKIPLEN: begin
          length_acc_next = acc_shift7;
          if (!b[7]) begin
            skip_remaining_next = acc_shift7;
            length_acc_next     = '0;
            phase_next          = (acc_shift7 == '0) ? end_phase : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) phase_next = end_phase;
        end
        default: ;
      endcase
    end
  end

  // Result for this byte
  always_comb begin
    res_valid    = 1'b0;
    res.kind     = K_NOTE_OFF;
    res.pitch    = '0;
    res.velocity = '0;
    res.tick     = 32'(cur_tick);
    if (active) begin
      case (cur_phase)
        PH_MAGIC: begin
          if (collect_done && (acc_shift8 != MAGIC_MTHD)) begin
            res_valid = 1'b1;
            res.kind  = K_BAD_MAGIC;
          end
        end
        PH_DIV: begin
          if (collect_done && acc_shift8[15]) begin
            res_valid = 1'b1;
            res.kind  = K_SMPTE;
          end
        end
        PH_TRKMAGIC: begin
          if (collect_done && (acc_shift8 != MAGIC_MTRK)) begin
            res_valid = 1'b1;
            res.kind  = K_BAD_MAGIC;
          end
        end
        PH_STATUS: begin
          if (!st_meta && !st_sysex && st_bad) begin
            res_valid = 1'b1;
            res.kind  = K_UNKNOWN;
          end
        end
        PH_DATA2: begin
          if (cs_type == ST_NOTE_OFF) begin
            res_valid = 1'b1;
            res.pitch = cur_pitch;
          end else if (cs_type == ST_NOTE_ON) begin
            res_valid    = 1'b1;
            res.kind     = (b == '0) ? K_NOTE_OFF : K_NOTE_ON;
            res.pitch    = cur_pitch;
            res.velocity = b;
          end
        end
        default: ;
      endcase
    end
  end

  // State update, one byte per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      hdr_count       <= '0;
      track_remaining <= '0;
      length_acc      <= '0;
      tick_count      <= '0;
      run_status      <= '0;
      current_status  <= '0;
      held_pitch      <= '0;
      skip_remaining  <= '0;
      halted          <= 1'b0;
    end else if (go) begin
      phase           <= phase_next;
      hdr_count       <= hdr_count_next;
      track_remaining <= track_remaining_next;
      length_acc      <= length_acc_next;
      tick_count      <= tick_count_next;
      run_status      <= run_status_next;
      current_status  <= current_status_next;
      held_pitch      <= held_pitch_next;
      skip_remaining  <= skip_remaining_next;
      halted          <= halted_next;
    end
  end

  // Error results
  assign res_err = res_valid &&
                   (res.kind == K_BAD_MAGIC || res.kind == K_SMPTE || res.kind == K_UNKNOWN);

  // Checks
  `MFTP_ASSERT_IMP(a_halt_quiet, clk, rst, go && cur_halted, !res_valid, "result while halted")
  `MFTP_ASSERT_NXT(a_err_halts, clk, rst, go && res_err, halted, "error did not halt parser")
  `MFTP_ASSERT_NXT(a_idle_hold, clk, rst, !go, $stable(phase) && $stable(tick_count), "idle move")

endmodule

/* rtl/core/mftp_out_reg.sv */
// ---------------------------------------------------------------------------
// mftp_out_reg
// Result register: holds one result until the receiver takes it.
// ---------------------------------------------------------------------------
module mftp_out_reg (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  mftp_pkg::mftp_result_t load_res,
  output logic                   out_free,
  output logic                   out_valid,
  input  logic                   out_stall,
  output mftp_pkg::mftp_result_t out_res
);
  import mftp_pkg::*;

  // Room for a new result when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

/* rtl/core/midi_file_track_event_parser.sv */
// Path: a transferred byte is held in the input register; when it moves on, its
//   result is loaded into the result register, from which the result transfers.
// Throughput: one byte per cycle; the input stalls only while a byte with a result
//   waits for a full result register to drain.
// Reset: synchronous; parser restarts in the header magic phase, both registers empty.
// ---------------------------------------------------------------------------
// midi_file_track_event_parser
// Standard MIDI file track parser: one byte in, at most one note or error
// result out, with input and result registers around the decode.
// ---------------------------------------------------------------------------
module midi_file_track_event_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [7:0]  pitch,
  output logic [7:0]  velocity,
  output logic [31:0] tick
);
  import mftp_pkg::*;

  mftp_item_t   in_item;
  mftp_item_t   item;
  logic         item_valid;
  logic         go;
  logic         res_valid;
  mftp_result_t res;
  logic         out_free;
  mftp_result_t out_res;

  assign in_item.data_byte  = data_byte;
  assign in_item.file_start = file_start;

  // Byte moves on unless its result has nowhere to go
  assign go = item_valid && (!res_valid || out_free);

  mftp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (go),
    .item_valid (item_valid),
    .item       (item)
  );

  mftp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mftp_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (go && res_valid),
    .load_res  (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign kind     = out_res.kind;
  assign pitch    = out_res.pitch;
  assign velocity = out_res.velocity;
  assign tick     = out_res.tick;

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI file track parser testbench
// Streams standard MIDI files into the parser one byte per transfer. The files
// are mostly well formed, with some corrupted magic, SMPTE division, odd track
// lengths, unknown status and noise. A byte-level predictor in the scoreboard
// computes the expected note and error events. Each event that leaves the block
// is checked field by field, in order. Both sides idle at random, and the result
// side sometimes holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import mftp_pkg::*;

  localparam int RANDOM_BYTES = 670;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 5_000_000;

  // Byte-level predictor of the parser plus the queue of events still due
  class track_event_check;
    phase_t               phase;
    logic [4:0]           hdr_cnt;
    logic [31:0]          trk_left, acc, skip_left;
    logic [TICK_BITS-1:0] ticks;
    logic [7:0]           run_st, cur_st, held_note;
    bit                   halted;
    mftp_result_t         due_events[$];
    int                   bad_events;

    function new();
      restart();
      bad_events = 0;
    endfunction

    function void restart();
      phase     = PH_MAGIC;
      hdr_cnt   = '0;
      trk_left  = '0;
      acc       = '0;
      ticks     = '0;
      run_st    = '0;
      cur_st    = '0;
      held_note = '0;
      skip_left = '0;
      halted    = 1'b0;
    endfunction

    // Shift a header byte in; true once n bytes of the field are in
    function bit gather(logic [7:0] b, logic [2:0] n);
      acc = {acc[23:0], b};
      hdr_cnt = hdr_cnt + 5'd1;
      return hdr_cnt >= n;
    endfunction

    function void next_field(phase_t ph);
      hdr_cnt = '0;
      acc     = '0;
      phase   = ph;
    endfunction

    function void event_done();
      phase = (trk_left == 0) ? PH_DONE : PH_DELTA;
    endfunction

    function void push(logic [2:0] k, logic [7:0] p, logic [7:0] v);
      mftp_result_t r;
      r.kind     = k;
      r.pitch    = p;
      r.velocity = v;
      r.tick     = 32'(ticks);
      due_events.push_back(r);
    endfunction

    function void fail(logic [2:0] k);
      halted = 1'b1;
      push(k, 8'h00, 8'h00);
    endfunction

    // First data byte: one-byte messages end here, others hold the note number
    function void first_data(logic [7:0] b);
      logic [7:0] st_type;
      st_type = cur_st & TYPE_MASK;
      if (st_type == ST_PROG_CHG || st_type == ST_CHAN_PRES) begin
        event_done();
      end else begin
        held_note = b;
        phase = PH_DATA2;
      end
    endfunction

    // Advance on one accepted byte; returns 0 when the byte is ignored
    function bit decode_byte(logic [7:0] b, logic fs);
      logic [7:0] st_type;
      if (fs) restart();
      if (halted || phase >= PH_DONE) return 1'b0;
      if (phase >= PH_DELTA && trk_left != 0) trk_left = trk_left - 1;
      case (phase)
        PH_MAGIC: begin
          if (gather(b, LEN_WORD)) begin
            if (acc != MAGIC_MTHD) fail(K_BAD_MAGIC);
            else next_field(PH_HDRLEN);
          end
        end
        PH_HDRLEN: begin
          if (gather(b, LEN_WORD)) next_field(PH_FMT);
        end
        PH_FMT: begin
          if (gather(b, LEN_WORD)) next_field(PH_DIV);
        end
        PH_DIV: begin
          if (gather(b, LEN_DIV)) begin
            if (acc[15]) fail(K_SMPTE);
            else next_field(PH_TRKMAGIC);
          end
        end
        PH_TRKMAGIC: begin
          if (gather(b, LEN_WORD)) begin
            if (acc != MAGIC_MTRK) fail(K_BAD_MAGIC);
            else next_field(PH_TRKLEN);
          end
        end
        PH_TRKLEN: begin
          if (gather(b, LEN_WORD)) begin
            trk_left = acc;
            next_field(PH_DELTA);
            ticks  = '0;
            run_st = '0;
            event_done();
          end
        end
        PH_DELTA: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            ticks = ticks + TICK_BITS'(acc);
            acc   = '0;
            phase = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            cur_st = b;
            if (b < ST_SYSEX) run_st = b;
          end else begin
            cur_st = run_st;
          end
          if (cur_st == ST_META) begin
            run_st = '0;
            phase  = PH_METATYPE;
          end else if (cur_st == ST_SYSEX || cur_st == ST_SYSEX_ESC) begin
            run_st = '0;
            acc    = '0;
            phase  = PH_SKIPLEN;
          end else begin
            st_type = cur_st & TYPE_MASK;
            if (st_type < ST_NOTE_OFF || st_type > ST_PITCH_BND) fail(K_UNKNOWN);
            else if (b[7]) phase = PH_DATA1;
            else first_data(b);  // running status: this is already data
          end
        end
        PH_DATA1: first_data(b);
        PH_DATA2: begin
          st_type = cur_st & TYPE_MASK;
          event_done();
          if (st_type == ST_NOTE_OFF) push(K_NOTE_OFF, held_note, 8'h00);
          else if (st_type == ST_NOTE_ON)
            push((b == 8'h00) ? K_NOTE_OFF : K_NOTE_ON, held_note, b);
        end
        PH_METATYPE: begin
          acc   = '0;
          phase = PH_SKIPLEN;
        end
        PH_SKIPLEN: begin
          acc = {acc[24:0], b[6:0]};
          if (!b[7]) begin
            skip_left = acc;
            acc = '0;
            if (skip_left == 0) event_done();
            else phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (skip_left != 0) skip_left = skip_left - 1;
          if (skip_left == 0) event_done();
        end
        default: ;
      endcase
      return 1'b1;
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
        bad_events++;
      end
    endfunction

    // Check one event leaving the block against the oldest one due
    function void check_event(logic [2:0] k, logic [7:0] p, logic [7:0] v,
                              logic [31:0] t);
      mftp_result_t want;
      if (due_events.size() == 0) begin
        $display("%0t ns: event expected none actual kind %0d pitch 0x%0h vel 0x%0h tick 0x%0h",
                 $time, k, p, v, t);
        bad_events++;
        return;
      end
      want = due_events.pop_front();
      compare("kind", 32'(want.kind), 32'(k));
      compare("pitch", 32'(want.pitch), 32'(p));
      compare("velocity", 32'(want.velocity), 32'(v));
      compare("tick", want.tick, t);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        file_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  pitch;
  logic [7:0]  velocity;
  logic [31:0] tick;

  track_event_check track_check;
  logic [7:0]       file_buf[$];
  logic [7:0]       track_buf[$];
  int               in_gap_pct = 25;
  int               sent_bytes = 0;
  bit               long_hold_req = 1'b0;

  midi_file_track_event_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .file_start (file_start),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .pitch      (pitch),
    .velocity   (velocity),
    .tick       (tick)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- stream building ----

  function automatic void put_word32(logic [31:0] w);
    for (int i = 3; i >= 0; i--) file_buf.push_back(w[8*i +: 8]);
  endfunction

  // Header chunk and track chunk head; length and format words are random
  function automatic void put_header(logic [31:0] mthd, logic [15:0] div,
                                     logic [31:0] mtrk, logic [31:0] trk_len);
    file_buf.delete();
    put_word32(mthd);
    put_word32($urandom());
    put_word32($urandom());
    file_buf.push_back(div[15:8]);
    file_buf.push_back(div[7:0]);
    put_word32(mtrk);
    put_word32(trk_len);
  endfunction

  // Variable-length delta: mostly one byte, sometimes long enough to wrap
  function automatic void put_delta();
    int n;
    n = ($urandom_range(0, 9) < 7) ? 1 : $urandom_range(2, 6);
    for (int i = 1; i < n; i++) track_buf.push_back(8'($urandom_range(128, 255)));
    track_buf.push_back(8'($urandom_range(0, 127)));
  endfunction

  function automatic logic [7:0] rand_data();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
    return 8'($urandom_range(0, 127));
  endfunction

  function automatic logic [7:0] rand_velocity();
    if ($urandom_range(0, 4) == 0) return 8'h00;
    return rand_data();
  endfunction

  function automatic bit one_data_byte(logic [7:0] st);
    return (st & TYPE_MASK) == ST_PROG_CHG || (st & TYPE_MASK) == ST_CHAN_PRES;
  endfunction

  // ---- driving ----

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < in_gap_pct)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    file_start <= fs;
    do @(posedge clk); while (in_stall);
    void'(track_check.decode_byte(b, fs));
    sent_bytes++;
  endtask

  task automatic send_file(input logic fs);
    foreach (file_buf[i]) send_byte(file_buf[i], (i == 0) ? fs : 1'b0);
  endtask

  // One random file: mostly well formed tracks, with broken headers, odd
  // track lengths, unknown status and noise mixed in
  task automatic random_file();
    int          n_events, pick, len;
    logic [7:0]  rs, st;
    logic [31:0] mthd, mtrk, trk_len;
    logic [15:0] div;
    track_buf.delete();
    rs = '0;
    n_events = $urandom_range(2, 14);
    for (int e = 0; e < n_events; e++) begin
      put_delta();
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        st = ((pick < 32) ? ST_NOTE_ON : ST_NOTE_OFF) | 8'($urandom_range(0, 15));
        rs = st;
        track_buf.push_back(st);
        track_buf.push_back(rand_data());
        track_buf.push_back(rand_velocity());
      end else if (pick < 62 && rs != '0) begin
        // running status: first data byte keeps its top bit clear
        track_buf.push_back(8'($urandom_range(0, 127)));
        if (!one_data_byte(rs)) track_buf.push_back(rand_velocity());
      end else if (pick < 74) begin
        // aftertouch, controller, program, pressure, pitch bend
        st = 8'($urandom_range(ST_NOTE_ON + 8'h10, ST_PITCH_BND + 8'h0F));
        rs = st;
        track_buf.push_back(st);
        track_buf.push_back(rand_data());
        if (!one_data_byte(st)) track_buf.push_back(rand_data());
      end else if (pick < 92) begin
        // meta or sysex: status, length, payload
        if (pick < 84) begin
          track_buf.push_back(ST_META);
          track_buf.push_back(8'($urandom()));
        end else begin
          track_buf.push_back($urandom_range(0, 1) ? ST_SYSEX : ST_SYSEX_ESC);
        end
        rs = '0;
        len = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) track_buf.push_back(8'h80);
        track_buf.push_back(8'(len));
        repeat (len) track_buf.push_back(8'($urandom()));
      end else if (pick < 97) begin
        // unknown system status, or a data byte with no running status
        st = 8'($urandom_range(ST_SYSEX + 8'h01, ST_META - 8'h02));
        if (st >= ST_SYSEX_ESC) st = st + 8'h01;
        if (rs == '0 && $urandom_range(0, 1)) st = 8'($urandom_range(0, 127));
        track_buf.push_back(st);
        break;
      end else begin
        track_buf.push_back(8'($urandom()));
      end
    end

    mthd = MAGIC_MTHD;
    mtrk = MAGIC_MTRK;
    if ($urandom_range(0, 99) < 6) mthd ^= 32'h1 << $urandom_range(0, 31);
    if ($urandom_range(0, 99) < 5) mtrk ^= 32'h1 << $urandom_range(0, 31);
    div = 16'($urandom_range(0, 16'h7FFF));
    if ($urandom_range(0, 99) < 6) div[15] = 1'b1;
    pick = $urandom_range(0, 99);
    if (pick < 75) trk_len = 32'(track_buf.size());
    else if (pick < 82) trk_len = '0;
    else if (pick < 91) trk_len = 32'($urandom_range(1, track_buf.size()));
    else trk_len = $urandom();

    put_header(mthd, div, mtrk, trk_len);
    foreach (track_buf[i]) file_buf.push_back(track_buf[i]);
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom()));

    case ($urandom_range(0, 3))
      0:       in_gap_pct = 0;
      3:       in_gap_pct = 60;
      default: in_gap_pct = 20;
    endcase
    send_file($urandom_range(0, 99) < 92);
  endtask

  // ---- result side ----

  // Random stall on the result port, with a long hold-off when requested
  initial begin : result_backpressure
    int span;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            out_stall <= 1'b1;
            span = $urandom_range(1, 3);
          end
          3: begin
            out_stall <= 1'b1;
            span = $urandom_range(8, 40);
          end
          4: begin
            out_stall <= 1'b0;
            span = $urandom_range(30, 120);
          end
          default: begin
            out_stall <= 1'b0;
            span = $urandom_range(1, 6);
          end
        endcase
        repeat (span) @(posedge clk);
      end
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      track_check.check_event(kind, pitch, velocity, tick);
  end

  // ---- test sequence ----

  initial begin : stimulus
    int waited;
    int file_no;
    track_check = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // No file start mark after reset, header magic off by one bit; the
    // byte after the error is ignored
    file_buf.delete();
    put_word32(MAGIC_MTHD ^ 32'h1);
    file_buf.push_back(8'h00);
    send_file(1'b0);

    // SMPTE division
    put_header(MAGIC_MTHD, 16'hE728, MAGIC_MTRK, 32'd0);
    send_file(1'b1);

    // One track: top pitch and velocity, running status with velocity zero,
    // a five-byte delta that takes the tick count to its top, note off with a
    // velocity, silent program change, empty meta, a delta that wraps the tick
    // count before a sysex escape, then a data byte with no running status
    track_buf = '{8'h00, ST_NOTE_ON, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'h00,
                  8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, ST_NOTE_OFF | 8'h0F, 8'h3C, 8'h40,
                  8'h00, ST_PROG_CHG, 8'h05,
                  8'h00, ST_META, 8'h2F, 8'h00,
                  8'h81, 8'h00, ST_SYSEX_ESC, 8'h02, 8'h11, 8'h22,
                  8'h00, 8'h3C, 8'h40};
    put_header(MAGIC_MTHD, 16'h01E0, MAGIC_MTRK, 32'(track_buf.size()));
    foreach (track_buf[i]) file_buf.push_back(track_buf[i]);
    send_file(1'b1);

    // Random files until enough bytes have been sent
    sent_bytes = 0;
    file_no = 0;
    while (sent_bytes < RANDOM_BYTES) begin
      if (file_no % 12 == 3) long_hold_req = 1'b1;
      random_file();
      file_no++;
    end
    in_valid <= 1'b0;

    waited = 0;
    while (track_check.due_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (track_check.due_events.size() != 0)
      $display("%0t ns: %0d expected events never arrived", $time,
               track_check.due_events.size());
    if (track_check.bad_events == 0 && track_check.due_events.size() == 0)
      $display("midi_file_track_event_parser regression: pass");
    else
      $display("midi_file_track_event_parser regression: fail");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("midi_file_track_event_parser regression: fail");
    $finish;
  end

endmodule
